// File: src/dps_pkg.sv
// Shared types, codes and defaults for the dynamic priority scheduler.
// Used by every module of the block but dps_ram; depends on nothing.
`timescale 1ns / 1ps

package dps_pkg;

  // Table size default and configuration port geometry
  localparam int MAX_PROCS_DEF = 16;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // Register indexes (word address paddr[2])
  localparam logic REG_PRIORITY_STEP = 1'b0;

  // Reset value of priority_step
  localparam logic [7:0] STEP_RESET = 8'd3;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_LOADED     = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_ZERO_NEED  = 3'd2;
  localparam logic [2:0] ST_DISPATCHED = 3'd3;
  localparam logic [2:0] ST_IDLE       = 3'd4;

  // Priority floor and used-slice ceiling
  localparam logic signed [9:0] PRIO_MIN = 10'sh200;
  localparam logic [7:0]        USED_MAX = 8'hFF;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [7:0]        id;
    logic signed [9:0] prio;
    logic [7:0]        used;
    logic [7:0]        needed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Entry after one dispatched slice
  typedef struct packed {
    entry_t ent;
    logic   fin;
  } upd_t;

endpackage

// File: src/dps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps

module dps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/dps_cfg.sv
// APB-style configuration register block: holds priority_step.
// Depends on dps_pkg.
`timescale 1ns / 1ps

module dps_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [dps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [dps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [7:0]                       priority_step
);
  import dps_pkg::*;

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      priority_step <= STEP_RESET;
    end else if (wr_en && reg_idx == REG_PRIORITY_STEP) begin
      priority_step <= pwdata[7:0];
    end
  end

  // read decode
  always_comb begin
    unique case (reg_idx)
      REG_PRIORITY_STEP: prdata = {{(CFG_DATA_W-8){1'b0}}, priority_step};
      default:           prdata = '0;
    endcase
  end

endmodule

// File: src/dps_alu.sv
// Shared compare and slice-update unit of the scheduler.
// Selects during the table scan and computes the dispatched entry; uses dps_pkg.
`timescale 1ns / 1ps

module dps_alu (
  input  logic            op,
  input  logic            slot_vld,
  input  logic            found,
  input  dps_pkg::entry_t rd_ent,
  input  dps_pkg::entry_t best_ent,
  input  logic [7:0]      step,
  output logic            sel,
  output dps_pkg::upd_t   upd
);
  import dps_pkg::*;

  logic signed [10:0] p_dec;

  // scan compare: first free slot for a load, strictly larger priority for a tick
  always_comb begin
    if (op == OP_LOAD) begin
      sel = !slot_vld && !found;
    end else begin
      sel = slot_vld && (!found || (rd_ent.prio > best_ent.prio));
    end
  end

  // one slice on the chosen entry
  assign p_dec = {best_ent.prio[9], best_ent.prio} - $signed({3'b000, step});

  always_comb begin
    upd.ent.id = best_ent.id;
    // saturate at the floor when the 11-bit result leaves the 10-bit range
    if (p_dec[10] != p_dec[9]) begin
      upd.ent.prio = PRIO_MIN;
    end else begin
      upd.ent.prio = p_dec[9:0];
    end
    upd.ent.used   = (best_ent.used == USED_MAX) ? USED_MAX : best_ent.used + 8'd1;
    upd.ent.needed = (best_ent.needed != 8'd0) ? best_ent.needed - 8'd1 : 8'd0;
    upd.fin        = (upd.ent.needed == 8'd0);
  end

endmodule

// File: src/dynamic_priority_scheduler.sv
// Dynamic priority scheduler top level: sequencer, valid bits and result register.
// Depends on dps_pkg, dps_ram, dps_cfg and dps_alu.
`timescale 1ns / 1ps

// Every item, load or tick, scans the whole process table, one RAM entry per
// cycle through a single compare unit, then writes the chosen slot back in the
// update state; that state waits while the output register holds a result not
// yet taken. The result beat is registered at the write-back. in_ready is high
// only while the sequencer is idle; a finished result may wait in the output
// register while the next item is taken. The table entries are undefined after
// reset: valid bits in flip-flops clear at reset, so no clearing pass is needed.
// priority_step is written over the APB-style port at address 0 and resets to 3.
module dynamic_priority_scheduler #(
  parameter int MAX_PROCS = dps_pkg::MAX_PROCS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [7:0]                     proc_id,
  input  logic signed [9:0]              start_priority,
  input  logic [7:0]                     used_slices,
  input  logic [7:0]                     needed_slices,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [7:0]                     run_id,
  output logic signed [9:0]              run_priority,
  output logic [7:0]                     run_used,
  output logic [7:0]                     run_remaining,
  output logic                           finished,
  output logic [4:0]                     ready_count
);
  import dps_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state, state_next;

  // captured input beat
  logic       op;
  entry_t     in_ent;

  // scan control
  logic [IW:0]   cnt;
  logic          cnt_done;
  logic          pend;
  logic [IW-1:0] pend_idx;

  // best candidate
  logic          found;
  logic [IW-1:0] best_idx;
  entry_t        best_ent;

  // table state
  logic [MAX_PROCS-1:0] valid;
  logic [CW-1:0]        occ;

  // datapath wires
  logic [7:0]          priority_step;
  logic [ENTRY_W-1:0]  rd_raw;
  entry_t              rd_ent;
  logic                sel;
  upd_t                upd;
  logic                fire;
  logic                load_ok;
  logic                ram_we;
  entry_t              wr_ent;

  dps_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .priority_step (priority_step)
  );

  dps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_idx),
    .wdata (wr_ent),
    .raddr (cnt[IW-1:0]),
    .rdata (rd_raw)
  );

  assign rd_ent = entry_t'(rd_raw);

  dps_alu u_alu (
    .op       (op),
    .slot_vld (valid[pend_idx]),
    .found    (found),
    .rd_ent   (rd_ent),
    .best_ent (best_ent),
    .step     (priority_step),
    .sel      (sel),
    .upd      (upd)
  );

  assign in_ready = (state == S_IDLE);
  assign cnt_done = (cnt == (IW+1)'(MAX_PROCS));
  assign fire     = (state == S_UPDATE) && (!out_valid || out_ready);
  assign load_ok  = found && (in_ent.needed != 8'd0);

  // write-back selection
  always_comb begin
    if (op == OP_LOAD) begin
      ram_we = fire && load_ok;
      wr_ent = in_ent;
    end else begin
      ram_we = fire && found;
      wr_ent = upd.ent;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (cnt_done) state_next = S_UPDATE;
      S_UPDATE: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op            <= operation;
      in_ent.id     <= proc_id;
      in_ent.prio   <= start_priority;
      in_ent.used   <= used_slices;
      in_ent.needed <= needed_slices;
    end
  end

  // table scan: issue one address a cycle, compare the entry read back
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (in_valid && in_ready) begin
      cnt   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (state == S_SCAN) begin
      pend <= !cnt_done;
      if (!cnt_done) begin
        cnt <= cnt + 1'b1;
      end
      if (pend && sel) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      pend_idx <= cnt[IW-1:0];
      if (pend && sel) begin
        best_idx <= pend_idx;
        best_ent <= rd_ent;
      end
    end
  end

  // valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (fire) begin
      if (op == OP_LOAD) begin
        if (load_ok) begin
          valid[best_idx] <= 1'b1;
          occ             <= occ + 1'b1;
        end
      end else if (found && upd.fin) begin
        valid[best_idx] <= 1'b0;
        occ             <= occ - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      run_id        <= '0;
      run_priority  <= '0;
      run_used      <= '0;
      run_remaining <= '0;
      finished      <= 1'b0;
      if (op == OP_LOAD) begin
        ready_count <= 5'(occ + CW'(load_ok));
        if (!found) begin
          status <= ST_FULL;
        end else if (!load_ok) begin
          status <= ST_ZERO_NEED;
        end else begin
          status <= ST_LOADED;
        end
      end else if (!found) begin
        status      <= ST_IDLE;
        ready_count <= 5'(occ);
      end else begin
        status        <= ST_DISPATCHED;
        run_id        <= upd.ent.id;
        run_priority  <= upd.ent.prio;
        run_used      <= upd.ent.used;
        run_remaining <= upd.ent.needed;
        finished      <= upd.fin;
        ready_count   <= 5'(occ - CW'(upd.fin));
      end
    end
  end

  // occupancy tracks the valid bits
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(occ))
    else $error("occupancy differs from number of valid slots");

  // occupancy never exceeds the table
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= MAX_PROCS)
    else $error("occupancy beyond table size");

  // a finished dispatch reports nothing remaining
  a_fin_remaining: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> (status == ST_DISPATCHED && run_remaining == 8'd0))
    else $error("finished flag without a completed dispatch");

  // each write-back leaves a fresh result beat
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("write-back without a result beat");

endmodule
